// ----- design/complex_arithmetic_unit_top_assert.svh -----
// Assertion macros used by the complex arithmetic unit checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// Clocked assertion that is off while reset is asserted.
`define CAU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication built on the macro above.
`define CAU_ASSERT_IMPL(name, ante, cons, msg) \
  `CAU_ASSERT(name, (ante) |-> (cons), msg)

`endif

// ----- design/cau_pkg.sv -----
// Types, constants and the saturation function of the complex arithmetic unit.
package cau_pkg;

  localparam int CW = 16;
  localparam int PW = 2 * CW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_e;

  typedef struct packed {
    cau_op_e              operation;
    logic signed [CW-1:0] a_real;
    logic signed [CW-1:0] a_imag;
    logic signed [CW-1:0] b_real;
    logic signed [CW-1:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [CW-1:0] result_real;
    logic signed [CW-1:0] result_imag;
    logic                 overflow;
    logic                 divide_by_zero;
  } cau_out_t;

  // Registered partial products and add/subtract sums.
  typedef struct packed {
    cau_op_e              op;
    logic signed [PW-1:0] ac;
    logic signed [PW-1:0] bd;
    logic signed [PW-1:0] ad;
    logic signed [PW-1:0] bc;
    logic signed [PW-1:0] cc;
    logic signed [PW-1:0] dd;
    logic signed [CW:0]   sum_re;
    logic signed [CW:0]   sum_im;
  } cau_prod_t;

  // One component of a divide in flight through the restoring divider.
  typedef struct packed {
    logic          neg;
    logic          big;
    logic [PW-1:0] rem;
    logic [CW-1:0] low;
    logic [CW-1:0] quo;
  } cau_lane_t;

  typedef struct packed {
    logic          is_div;
    cau_out_t      res;
    logic [PW-1:0] den;
    cau_lane_t     re;
    cau_lane_t     im;
  } cau_div_t;

  typedef struct packed {
    logic signed [CW-1:0] val;
    logic                 ovf;
  } cau_sat_t;

  localparam logic signed [PW:0] SAT_MAX = (PW+1)'((1 << (CW - 1)) - 1);
  localparam logic signed [PW:0] SAT_MIN = ~SAT_MAX;

  function automatic cau_sat_t cau_sat(input logic signed [PW:0] v);
    cau_sat_t r;
    if (v > SAT_MAX) begin
      r.val = SAT_MAX[CW-1:0];
      r.ovf = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = SAT_MIN[CW-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[CW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- design/cau_mult.sv -----
// First pipeline stage: the six component products and the add/subtract sums.
module cau_mult import cau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  cau_in_t   data_i,
  output logic      valid_o,
  output cau_prod_t data_o
);

  logic      valid_q;
  cau_prod_t data_d, data_q;

  always_comb begin
    data_d.op = data_i.operation;
    data_d.ac = data_i.a_real * data_i.b_real;
    data_d.bd = data_i.a_imag * data_i.b_imag;
    data_d.ad = data_i.a_real * data_i.b_imag;
    data_d.bc = data_i.a_imag * data_i.b_real;
    data_d.cc = data_i.b_real * data_i.b_real;
    data_d.dd = data_i.b_imag * data_i.b_imag;
    if (data_i.operation == OP_SUB) begin
      data_d.sum_re = data_i.a_real - data_i.b_real;
      data_d.sum_im = data_i.a_imag - data_i.b_imag;
    end else begin
      data_d.sum_re = data_i.a_real + data_i.b_real;
      data_d.sum_im = data_i.a_imag + data_i.b_imag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/cau_combine.sv -----
// Stages two and three: product sums, non-divide results, divider setup.
module cau_combine import cau_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] en_i,
  input  logic       valid_i,
  input  cau_prod_t  data_i,
  output logic [1:0] valid_o,
  output cau_div_t   data_o
);

  typedef struct packed {
    logic          is_div;
    cau_out_t      res;
    logic [PW-1:0] den;
    logic          nr_neg;
    logic [PW-1:0] nr_mag;
    logic          ni_neg;
    logic [PW-1:0] ni_mag;
  } mid_t;

  logic [1:0]        valid_q;
  mid_t              mid_d, mid_q;
  cau_div_t          div_d, div_q;
  logic signed [PW:0] pr, pi, nr, ni, nr_n, ni_n, rr, ri;
  logic [PW-1:0]     den;
  cau_sat_t          s_re, s_im;

  // The numerator is scaled by the fraction bits; its upper part is the
  // starting remainder, and a quotient that needs more than CW bits saturates.
  function automatic cau_lane_t lane_init(input logic neg, input logic [PW-1:0] mag,
                                          input logic [PW-1:0] dv);
    logic [PW+FRACTION_BITS-1:0] x;
    logic [PW-1:0]               rem0;
    cau_lane_t                   l;
    x      = (PW+FRACTION_BITS)'(mag) << FRACTION_BITS;
    rem0   = PW'(x[PW+FRACTION_BITS-1:CW]);
    l.neg  = neg;
    l.big  = (rem0 >= dv);
    l.rem  = rem0;
    l.low  = x[CW-1:0];
    l.quo  = '0;
    return l;
  endfunction

  always_comb begin
    pr   = {data_i.ac[PW-1], data_i.ac} - {data_i.bd[PW-1], data_i.bd};
    pi   = {data_i.ad[PW-1], data_i.ad} + {data_i.bc[PW-1], data_i.bc};
    nr   = {data_i.ac[PW-1], data_i.ac} + {data_i.bd[PW-1], data_i.bd};
    ni   = {data_i.bc[PW-1], data_i.bc} - {data_i.ad[PW-1], data_i.ad};
    nr_n = -nr;
    ni_n = -ni;
    den  = data_i.cc[PW-1:0] + data_i.dd[PW-1:0];
    unique case (data_i.op)
      OP_ADD, OP_SUB: begin
        rr = {{(PW-CW){data_i.sum_re[CW]}}, data_i.sum_re};
        ri = {{(PW-CW){data_i.sum_im[CW]}}, data_i.sum_im};
      end
      OP_MUL: begin
        // Arithmetic shift gives the floor of the scaled product.
        rr = pr >>> FRACTION_BITS;
        ri = pi >>> FRACTION_BITS;
      end
      default: begin
        rr = '0;
        ri = '0;
      end
    endcase
    s_re = cau_sat(rr);
    s_im = cau_sat(ri);

    mid_d.is_div             = (data_i.op == OP_DIV);
    mid_d.res.result_real    = s_re.val;
    mid_d.res.result_imag    = s_im.val;
    mid_d.res.overflow       = s_re.ovf | s_im.ovf;
    mid_d.res.divide_by_zero = (data_i.op == OP_DIV) && (den == '0);
    mid_d.den                = den;
    mid_d.nr_neg             = nr[PW];
    mid_d.nr_mag             = nr[PW] ? nr_n[PW-1:0] : nr[PW-1:0];
    mid_d.ni_neg             = ni[PW];
    mid_d.ni_mag             = ni[PW] ? ni_n[PW-1:0] : ni[PW-1:0];
  end

  always_comb begin
    div_d.is_div = mid_q.is_div;
    div_d.res    = mid_q.res;
    div_d.den    = mid_q.den;
    div_d.re     = lane_init(mid_q.nr_neg, mid_q.nr_mag, mid_q.den);
    div_d.im     = lane_init(mid_q.ni_neg, mid_q.ni_mag, mid_q.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) begin
        valid_q[0] <= valid_i;
      end
      if (en_i[1]) begin
        valid_q[1] <= valid_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mid_q <= mid_d;
    end
    if (en_i[1]) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = div_q;

endmodule

// ----- design/cau_div_step.sv -----
// One restoring-division stage: one quotient bit for each component.
module cau_div_step import cau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  cau_div_t data_i,
  output logic     valid_o,
  output cau_div_t data_o
);

  logic     valid_q;
  cau_div_t data_d, data_q;

  function automatic cau_lane_t lane_step(input cau_lane_t l, input logic [PW-1:0] dv);
    logic [PW:0] r2;
    logic [PW:0] diff;
    cau_lane_t   n;
    n     = l;
    r2    = {l.rem, l.low[CW-1]};
    diff  = r2 - {1'b0, dv};
    n.low = {l.low[CW-2:0], 1'b0};
    if (r2 >= {1'b0, dv}) begin
      n.rem = diff[PW-1:0];
      n.quo = {l.quo[CW-2:0], 1'b1};
    end else begin
      n.rem = r2[PW-1:0];
      n.quo = {l.quo[CW-2:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    data_d    = data_i;
    data_d.re = lane_step(data_i.re, data_i.den);
    data_d.im = lane_step(data_i.im, data_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/complex_arithmetic_unit_top.sv -----
// A result passes through CW + 4 register stages from input transfer to output.
// One item per cycle unless stalled; the 16 divider stages resolve a bit each.
// A stage holds only while it and every stage after it are full and the output
// stalls, so bubbles close up and input is taken while a result waits.
// Reset clears all valid bits; payload registers are not reset.
module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cau_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cau_out_t out_data_o
);

  localparam int NS = CW + 4;

  logic [NS-1:0] stg_v, stg_en;
  cau_prod_t     prod;
  cau_div_t      div_data [CW+1];
  cau_out_t      out_d, out_q;
  logic          out_valid_q;
  cau_sat_t      f_re, f_im;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign stg_en[k] = !(out_stall_i && (&stg_v[NS-1:k]));
  end

  assign stg_v[NS-1] = out_valid_q;
  assign in_stall_o  = !stg_en[0];

  cau_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (stg_en[0]),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (stg_v[0]),
    .data_o  (prod)
  );

  cau_combine #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (stg_en[2:1]),
    .valid_i (stg_v[0]),
    .data_i  (prod),
    .valid_o (stg_v[2:1]),
    .data_o  (div_data[0])
  );

  for (genvar g = 0; g < CW; g++) begin : g_div
    cau_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (stg_en[3+g]),
      .valid_i (stg_v[2+g]),
      .data_i  (div_data[g]),
      .valid_o (stg_v[3+g]),
      .data_o  (div_data[g+1])
    );
  end

  // A quotient that overflowed the divider is forced past the range.
  function automatic cau_sat_t lane_result(input cau_lane_t l);
    logic signed [PW:0] m;
    m = l.big ? ((PW+1)'(1) << CW) : (PW+1)'(l.quo);
    if (l.neg) begin
      m = -m;
    end
    return cau_sat(m);
  endfunction

  always_comb begin
    f_re = lane_result(div_data[CW].re);
    f_im = lane_result(div_data[CW].im);
    if (div_data[CW].is_div && !div_data[CW].res.divide_by_zero) begin
      out_d.result_real    = f_re.val;
      out_d.result_imag    = f_im.val;
      out_d.overflow       = f_re.ovf | f_im.ovf;
      out_d.divide_by_zero = 1'b0;
    end else begin
      out_d = div_data[CW].res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_en[NS-1]) begin
      out_valid_q <= stg_v[NS-2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/cau_checker.sv -----
// Port-level checks of the complex arithmetic unit, bound to the top level.
`include "complex_arithmetic_unit_top_assert.svh"

module cau_checker import cau_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input cau_out_t out_data_o
);

  // The input only stalls when the whole pipeline is full behind a stalled result.
  `CAU_ASSERT_IMPL(a_in_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without a blocked output")

  `CAU_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")

  `CAU_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o), "stalled result changed")

  // A zero divisor yields a zero result with no saturation.
  `CAU_ASSERT_IMPL(a_dz_zero, out_valid_o && out_data_o.divide_by_zero, out_data_o.result_real == 0 && out_data_o.result_imag == 0 && !out_data_o.overflow, "divide by zero result not cleared")

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);
